// ===== hw/rtl/sliding_truncated_mean_filter_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sliding truncated mean filter
// Checks are compiled in for simulation and left empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef SLIDING_TRUNCATED_MEAN_FILTER_TOP_DEFINES_SVH
`define SLIDING_TRUNCATED_MEAN_FILTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// check a property while out of reset
`define STM_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("stm check failed");
// check a property at every edge, reset included
`define STM_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("stm check failed");
`else
`define STM_ASSERT(label, clk, rst_n, prop)
`define STM_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== hw/rtl/stm_pkg.sv =====
// ---------------------------------------------------------------------------
// stm_pkg
// Sizes, types and cell control bundle of the sliding truncated mean filter.
// ---------------------------------------------------------------------------
package stm_pkg;

	localparam int RADIUS = 8;
	localparam int WIN    = 2 * RADIUS + 1;
	localparam int IDX_W  = $clog2(WIN);
	localparam int CNT_W  = $clog2(WIN + 1);
	localparam int RAD_W  = $clog2(RADIUS + 1);
	localparam int CHG_W  = 12;
	localparam int MEAN_W = 16;
	localparam int HIT_W  = 16;
	localparam int FRAC_W = 4;
	localparam int SUM_W  = $clog2(WIN * ((1 << CHG_W) - 1) + 1);
	localparam int NUM_W  = SUM_W + FRAC_W;
	localparam int STEP_W = $clog2(NUM_W + 1);

	typedef logic [CHG_W-1:0] charge_t;

	// value with a flag that says it belongs to the current window
	typedef struct packed {
		logic    act;
		charge_t val;
	} tok_t;

	typedef struct packed {
		logic             shift_win;
		logic             load;
		logic             rank_en;
		logic             mark;
		logic             sum_shift;
		logic [IDX_W-1:0] lim;
		logic [IDX_W-1:0] k;
		logic [CNT_W-1:0] t;
		logic [CNT_W-1:0] hi;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/stm_cell.sv =====
// ---------------------------------------------------------------------------
// stm_cell
// One window cell: holds a charge, ranks it against a rotating probe ring
// and hands its value down a drain chain when it survives the trim.
// ---------------------------------------------------------------------------
module stm_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  stm_pkg::cell_ctl_t      ctl,
	input  logic [stm_pkg::IDX_W-1:0] idx,
	input  stm_pkg::charge_t        win_in,
	output stm_pkg::charge_t        win_out,
	input  stm_pkg::tok_t           probe_in,
	output stm_pkg::tok_t           probe_out,
	input  stm_pkg::tok_t           sum_in,
	output stm_pkg::tok_t           sum_out
);
	import stm_pkg::*;

	charge_t          win_q;
	charge_t          val_q;
	tok_t             probe_q;
	tok_t             sum_q;
	logic             act_q;
	logic [IDX_W-1:0] rank_q;
	logic             in_win;
	logic             beats;
	logic             kept;

	assign in_win = (idx <= ctl.lim);

	// probe from an earlier slot wins a tie, so equal values get distinct ranks
	assign beats = probe_in.act && act_q &&
		((probe_in.val < val_q) || ((probe_in.val == val_q) && (ctl.k <= idx)));

	assign kept = act_q && (CNT_W'(rank_q) >= ctl.t) && (CNT_W'(rank_q) < ctl.hi);

	always_ff @(posedge clk) begin
		if (ctl.shift_win) begin
			win_q <= win_in;
		end
		if (ctl.load) begin
			val_q   <= win_q;
			probe_q <= '{act: in_win, val: win_q};
		end else if (ctl.rank_en) begin
			probe_q <= probe_in;
		end
		if (ctl.mark) begin
			sum_q <= '{act: kept, val: val_q};
		end else if (ctl.sum_shift) begin
			sum_q <= sum_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			rank_q <= '0;
		end else if (ctl.load) begin
			act_q  <= in_win;
			rank_q <= '0;
		end else if (ctl.rank_en && beats) begin
			rank_q <= rank_q + 1'b1;
		end
	end

	assign win_out   = win_q;
	assign probe_out = probe_q;
	assign sum_out   = sum_q;

endmodule

// ===== hw/rtl/stm_div.sv =====
// ---------------------------------------------------------------------------
// stm_div
// Restoring divider, one quotient bit per cycle, for the scaled window sum.
// ---------------------------------------------------------------------------
module stm_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [stm_pkg::NUM_W-1:0]  num,
	input  logic [stm_pkg::CNT_W-1:0]  den,
	output logic                       busy,
	output logic                       done,
	output logic [stm_pkg::MEAN_W-1:0] quo
);
	import stm_pkg::*;

	logic [CNT_W:0]    rem_q;
	logic [NUM_W-1:0]  q_q;
	logic [CNT_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W:0]    rem_sh;
	logic              ge;

	assign rem_sh = {rem_q[CNT_W-1:0], q_q[NUM_W-1]};
	assign ge     = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q   <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
			q_q   <= {q_q[NUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(NUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = (den_q == '0) ? '0 : q_q[MEAN_W-1:0];

endmodule

// ===== hw/rtl/sliding_truncated_mean_filter_top.sv =====
// ---------------------------------------------------------------------------
// sliding_truncated_mean_filter_top
// Trimmed mean of a centred, track-clipped window of hit charges.
// ---------------------------------------------------------------------------
// A hit that produces no result is accepted without leaving the idle state.
// Each result passes through a load, the probe ring ranking the window in
// the cell chain, a mark, draining the kept values into the adder, the
// bit-serial divider and a step that registers the result; a hit that
// yields a result is first accepted in the idle state, no further hit is
// taken until its results are registered, and a stalled output adds its stall.
// A hit closing a track flushes up to RADIUS+1 results before the next hit
// is taken. Results trail the input by RADIUS hits.
`include "sliding_truncated_mean_filter_top_defines.svh"

module sliding_truncated_mean_filter_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [stm_pkg::CHG_W-1:0]   charge,
	input  logic                        track_end,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [stm_pkg::MEAN_W-1:0]  trimmed_mean,
	output logic                        last
);
	import stm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_RANK, ST_MARK, ST_SUM, ST_DIV, ST_OUT
	} state_t;

	state_t            state_q;
	logic [HIT_W-1:0]  h_q;
	logic [HIT_W-1:0]  n_q;
	logic [HIT_W-1:0]  c_q;
	logic [RAD_W-1:0]  dist_q;
	logic              end_q;
	logic [IDX_W-1:0]  k_q;
	logic [CNT_W-1:0]  t_q;
	logic [CNT_W-1:0]  hi_q;
	logic [CNT_W-1:0]  m_q;
	logic [SUM_W-1:0]  acc_q;
	logic              out_valid_q;
	logic [MEAN_W-1:0] mean_q;
	logic              last_q;

	logic [HIT_W-1:0]  d_raw;
	logic [RAD_W-1:0]  d_cl;
	logic [RAD_W-1:0]  prior;
	logic [IDX_W-1:0]  lim;
	logic [CNT_W-1:0]  cnt;
	logic [CNT_W-1:0]  t_nx;
	logic [SUM_W-1:0]  acc_nx;
	logic              accept;
	logic              sum_last;
	logic              div_start;
	logic              div_busy;
	logic              div_done;
	logic [MEAN_W-1:0] div_quo;
	cell_ctl_t         ctl;

	charge_t           win_w   [WIN];
	tok_t              probe_w [WIN];
	tok_t              sum_w   [WIN];

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	assign d_raw  = h_q - n_q;
	assign d_cl   = (d_raw > HIT_W'(RADIUS)) ? RAD_W'(RADIUS) : d_raw[RAD_W-1:0];
	assign prior  = (c_q < HIT_W'(RADIUS)) ? c_q[RAD_W-1:0] : RAD_W'(RADIUS);
	assign lim    = IDX_W'(dist_q) + IDX_W'(prior);
	assign cnt    = CNT_W'(lim) + 1'b1;
	assign t_nx   = cnt >> 2;

	assign acc_nx   = acc_q + (sum_w[WIN-1].act ? SUM_W'(sum_w[WIN-1].val) : '0);
	assign sum_last = (state_q == ST_SUM) && (k_q == IDX_W'(WIN - 1));
	assign div_start = sum_last;

	assign ctl.shift_win = accept;
	assign ctl.load      = (state_q == ST_LOAD);
	assign ctl.rank_en   = (state_q == ST_RANK);
	assign ctl.mark      = (state_q == ST_MARK);
	assign ctl.sum_shift = (state_q == ST_SUM);
	assign ctl.lim       = lim;
	assign ctl.k         = k_q;
	assign ctl.t         = t_q;
	assign ctl.hi        = hi_q;

	for (genvar i = 0; i < WIN; i++) begin : g_cell
		stm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.idx       (IDX_W'(i)),
			.win_in    ((i == 0) ? charge : win_w[(i + WIN - 1) % WIN]),
			.win_out   (win_w[i]),
			.probe_in  (probe_w[(i + WIN - 1) % WIN]),
			.probe_out (probe_w[i]),
			.sum_in    ((i == 0) ? tok_t'('0) : sum_w[(i + WIN - 1) % WIN]),
			.sum_out   (sum_w[i])
		);
	end

	stm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({acc_nx, FRAC_W'(0)}),
		.den    (m_q),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			t_q  <= t_nx;
			hi_q <= cnt - t_nx;
			m_q  <= cnt - (t_nx << 1);
		end
		if (state_q == ST_MARK) begin
			acc_q <= '0;
		end else if (state_q == ST_SUM) begin
			acc_q <= acc_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			h_q         <= '0;
			n_q         <= '0;
			c_q         <= '0;
			dist_q      <= '0;
			end_q       <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			mean_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						c_q    <= n_q;
						dist_q <= d_cl;
						end_q  <= track_end;
						if (track_end) begin
							h_q     <= '0;
							n_q     <= '0;
							state_q <= ST_LOAD;
						end else begin
							h_q <= h_q + 1'b1;
							if (d_cl == RAD_W'(RADIUS)) begin
								n_q     <= n_q + 1'b1;
								state_q <= ST_LOAD;
							end
						end
					end
				end
				ST_LOAD: begin
					k_q     <= IDX_W'(1);
					state_q <= ST_RANK;
				end
				ST_RANK: begin
					k_q <= k_q + 1'b1;
					if (k_q == IDX_W'(WIN - 1)) begin
						state_q <= ST_MARK;
					end
				end
				ST_MARK: begin
					k_q     <= '0;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					k_q <= k_q + 1'b1;
					if (sum_last) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold the result until the output register frees up
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						mean_q      <= div_quo;
						last_q      <= end_q && (dist_q == '0);
						if (end_q && (dist_q != '0)) begin
							c_q     <= c_q + 1'b1;
							dist_q  <= dist_q - 1'b1;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign trimmed_mean = mean_q;
	assign last         = last_q;

	`STM_ASSERT(a_lag_in_range, clk, arst_n, (h_q - n_q) <= HIT_W'(RADIUS))
	`STM_ASSERT(a_done_in_div, clk, arst_n, div_done |-> (state_q == ST_DIV))
	`STM_ASSERT(a_busy_in_div, clk, arst_n, div_busy |-> (state_q == ST_DIV))
	`STM_ASSERT_ALWAYS(a_idle_no_div, clk, in_ready |-> !div_busy)

endmodule
